// ----- hdl/swm_pkg.sv -----
// Shared types and constants for the sliding-window median filter.
`default_nettype none

package swm_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_W     = 32;
  localparam int CFG_W        = 7;
  localparam int MEDIAN_W     = SAMPLE_W + 1;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEDIAN_W-1:0] median_t;
  typedef logic [CFG_W-1:0]           window_t;

  typedef struct packed {
    sample_t sample;
    logic    stream_start;
  } in_item_t;

  typedef struct packed {
    median_t median_twice;
  } out_item_t;

  // Control from the pipeline to the sorted store
  typedef struct packed {
    logic upd;    // apply the staged sample
    logic start;  // empty the window before the staged sample
    logic clear;  // empty the window (configuration write)
  } sort_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/swm_chan_if.sv -----
// Valid/ready channel interface carrying one payload item.
`default_nettype none

interface swm_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/sliding_window_median.sv -----
// An accepted item passes the input register, the sorted store and the result register.
// Throughput: one item per cycle while results are taken; the sorted store updates all entries at once.
// An input register lets an item in while a finished result waits downstream.
// Reset: window_size returns to 3 and the window is empty; no clearing pass.
// The first win - 1 items of a stream (window_size clamped into 1..MAX_WINDOW) give no result.
`default_nettype none

module sliding_window_median #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW
) (
  input logic         clk,
  input logic         rst,
  swm_chan_if.sink    samples,
  swm_chan_if.source  medians,
  swm_chan_if.sink    cfg
);

  localparam int CW = $clog2(MAX_WINDOW + 1);

  // Window length register, clamped into 1..MAX_WINDOW for use
  swm_pkg::window_t window_size;
  logic [CW-1:0]    win;
  logic             cfg_wr;

  // Input stage
  logic             in_full;
  swm_pkg::sample_t in_sample;
  logic             in_start;

  // Middle stage: store updated, result pending
  logic             mid_valid;

  // Shared pipeline enable: move when the result register is free or being taken
  logic             advance;
  logic             upd;

  swm_pkg::sort_ctl_t ctl;
  swm_pkg::sample_t   vals [MAX_WINDOW];
  logic               fills_window;
  swm_pkg::median_t   median_twice;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::WINDOW_RESET;
    end else if (cfg_wr) begin
      window_size <= cfg.data;
    end
  end

  always_comb begin
    priority if (window_size == '0) begin
      win = CW'(1);
    end else if (32'(window_size) > MAX_WINDOW) begin
      win = CW'(MAX_WINDOW);
    end else begin
      win = CW'(window_size);
    end
  end

  assign advance       = !medians.valid || medians.ready;
  assign upd           = in_full && advance;
  // Take a new item whenever the input register is empty or drains this cycle
  assign samples.ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      in_full <= 1'b1;
    end else if (upd) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_sample <= samples.data.sample;
      in_start  <= samples.data.stream_start;
    end
  end

  assign ctl.upd   = upd;
  assign ctl.start = in_start;
  assign ctl.clear = cfg_wr;

  swm_sorter #(.MAX_WINDOW(MAX_WINDOW)) u_sorter (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sample       (in_sample),
    .win          (win),
    .vals         (vals),
    .fills_window (fills_window)
  );

  // Mark a result once the item just applied leaves the window full
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (advance) begin
      mid_valid <= upd && fills_window;
    end
  end

  // Read the two middle entries of the store as it stands after that item
  swm_median #(.MAX_WINDOW(MAX_WINDOW)) u_median (
    .vals         (vals),
    .win          (win),
    .median_twice (median_twice)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      medians.valid <= 1'b0;
    end else if (advance) begin
      medians.valid <= mid_valid;
    end
  end

  // Hold the result payload until taken
  always_ff @(posedge clk) begin
    if (advance && mid_valid) begin
      medians.data.median_twice <= median_twice;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/swm_sorter.sv -----
// Sorted window store: parallel remove-oldest and insert-new in a single update.
`default_nettype none

module swm_sorter #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW
) (
  input  logic                               clk,
  input  logic                               rst,
  input  swm_pkg::sort_ctl_t                 ctl,
  input  swm_pkg::sample_t                   sample,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]    win,
  output swm_pkg::sample_t                   vals [MAX_WINDOW],
  output logic                               fills_window
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [AW-1:0]         ages      [MAX_WINDOW];
  swm_pkg::sample_t      vals_next [MAX_WINDOW];
  logic [AW-1:0]         ages_next [MAX_WINDOW];
  logic [CW-1:0]         fill;
  logic [CW-1:0]         fill_next;
  logic [CW-1:0]         fill_eff;
  logic [AW-1:0]         oldest_age;
  logic                  full;
  logic [MAX_WINDOW-1:0] live, del, lt, before_del, stay, mov_up, mov_dn;

  assign fill_eff   = ctl.start ? '0 : fill;
  assign full       = fill_eff >= win;
  assign oldest_age = AW'(win - CW'(1));
  assign fill_next  = full ? fill_eff : fill_eff + CW'(1);
  assign fills_window = (fill_next == win);

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cmp
    assign live[i] = CW'(i) < fill_eff;
    assign del[i]  = full && live[i] && (ages[i] == oldest_age);
    assign lt[i]   = vals[i] < sample;
    if (i == 0) begin : g_first
      assign before_del[i] = 1'b0;
    end else begin : g_rest
      assign before_del[i] = |del[i-1:0];
    end
    // Entries >= sample below the removed one move up; those < sample past it move down
    assign stay[i]   = live[i] && !del[i] && (!lt[i] == before_del[i]);
    assign mov_up[i] = live[i] && !del[i] && !lt[i] && !before_del[i];
    assign mov_dn[i] = live[i] && !del[i] && lt[i] && before_del[i];
  end

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_slot
    logic from_above, from_below;
    if (j + 1 < MAX_WINDOW) begin : g_above
      assign from_above = mov_dn[j+1];
    end else begin : g_no_above
      assign from_above = 1'b0;
    end
    if (j > 0) begin : g_below
      assign from_below = mov_up[j-1];
    end else begin : g_no_below
      assign from_below = 1'b0;
    end

    always_comb begin
      priority if (from_above) begin
        vals_next[j] = vals[(j + 1 < MAX_WINDOW) ? j + 1 : j];
        ages_next[j] = ages[(j + 1 < MAX_WINDOW) ? j + 1 : j] + AW'(1);
      end else if (stay[j]) begin
        vals_next[j] = vals[j];
        ages_next[j] = ages[j] + AW'(1);
      end else if (from_below) begin
        vals_next[j] = vals[(j > 0) ? j - 1 : j];
        ages_next[j] = ages[(j > 0) ? j - 1 : j] + AW'(1);
      end else begin
        // Unclaimed slot takes the new sample
        vals_next[j] = sample;
        ages_next[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.clear) begin
      fill <= '0;
    end else if (ctl.upd) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      vals <= vals_next;
      ages <= ages_next;
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= win)
    else $error("fill count exceeds window");

  a_single_removal: assert property (@(posedge clk) disable iff (rst)
    $countones(del) <= 1)
    else $error("more than one entry removed");

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    ctl.upd && ctl.start && !ctl.clear |=> fill == CW'(1))
    else $error("stream start did not restart the window");

endmodule

`default_nettype wire

// ----- hdl/swm_median.sv -----
// Median pick: selects the two middle entries (the middle one twice for an odd window) and sums them.
`default_nettype none

module swm_median #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW
) (
  input  swm_pkg::sample_t                vals [MAX_WINDOW],
  input  logic [$clog2(MAX_WINDOW+1)-1:0] win,
  output swm_pkg::median_t                median_twice
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [AW-1:0]    lo_idx, hi_idx;
  swm_pkg::sample_t lo_val, hi_val;

  assign lo_idx = AW'((win - CW'(1)) >> 1);
  assign hi_idx = AW'(win >> 1);

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (AW'(i) == lo_idx) lo_val = lo_val | vals[i];
      if (AW'(i) == hi_idx) hi_val = hi_val | vals[i];
    end
  end

  assign median_twice = {lo_val[swm_pkg::SAMPLE_W-1], lo_val}
                      + {hi_val[swm_pkg::SAMPLE_W-1], hi_val};

endmodule

`default_nettype wire
